// ----- rtl/gnomonic_forward_projection_defines.svh -----
// ---------------------------------------------------------------------------
// Gnomonic projection assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef GNOMONIC_FORWARD_PROJECTION_DEFINES_SVH
`define GNOMONIC_FORWARD_PROJECTION_DEFINES_SVH

// same-cycle implication, off during reset
`define GFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define GFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define GFP_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gfp_pkg.sv -----
// ---------------------------------------------------------------------------
// Gnomonic projection package
// Widths, constants, lane types and elaboration-time CORDIC tables.
// ---------------------------------------------------------------------------
`default_nettype none

package gfp_pkg;

    localparam int ANGLE_FRAC_BITS   = 16;
    localparam int CORDIC_STAGES_DEF = 32;

    // port widths
    localparam int LAT_W      = 24;
    localparam int LON_W      = 25;
    localparam int RAD_W      = 24;
    localparam int OUT_W      = 48;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_LAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_LON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(6378137);

    // internal widths
    localparam int ANG_W   = 26;   // angle into a sin/cos unit
    localparam int WRAP_W  = 25;   // angle in [-180, 180)
    localparam int RED_W   = 24;   // angle in [-90, 90]
    localparam int X_W     = 42;   // CORDIC x/y, Q40
    localparam int Z_W     = 62;   // CORDIC z, Q60
    localparam int TRIG_W  = 32;   // sin/cos, Q30
    localparam int PROD_W  = 62;   // Q60 products
    localparam int NUMER_W = 33;   // cos c and numerators, Q30
    localparam int NUM_W   = 58;   // radius times numerator
    localparam int MAG_W   = 57;   // dividend magnitude / quotient
    localparam int DIV_W   = 32;   // divisor
    localparam int REM_W   = 33;   // partial remainder

    localparam longint FULL_TURN    = longint'(360) << ANGLE_FRAC_BITS;
    localparam longint HALF_TURN    = longint'(180) << ANGLE_FRAC_BITS;
    localparam longint QUARTER_TURN = longint'(90) << ANGLE_FRAC_BITS;

    // unsigned quotient by shift and subtract, for table setup only
    function automatic longint unsigned udiv64(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[62:0], a[j]};
            if (r >= b) begin
                r    = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in Q60, truncated series
    function automatic longint unsigned atan_recip(input longint unsigned n);
        longint unsigned term;
        longint unsigned sum;
        longint unsigned n2;
        term = udiv64(64'd1 << 60, n);
        sum  = term;
        n2   = n * n;
        for (longint unsigned k = 1; k < 64; k++) begin
            term = udiv64(term, n2);
            if (term != 0) begin
                if (k[0])
                    sum = sum - udiv64(term, 2 * k + 1);
                else
                    sum = sum + udiv64(term, 2 * k + 1);
            end
        end
        return sum;
    endfunction

    function automatic longint unsigned atan_q60(input int i);
        if (i == 0)
            return atan_recip(64'd2) + atan_recip(64'd3);
        else if (i < 20)
            return atan_recip(64'd1 << i);
        else
            return 64'd1 << (60 - i);
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > v)
                b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // 1/gain in Q40 for a given number of rotations
    function automatic longint unsigned cordic_inv_gain(input int n);
        longint unsigned p;
        longint unsigned s;
        p = 64'd1 << 60;
        for (int i = 0; i < n; i++) begin
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        end
        s = isqrt64(p);
        return udiv64((64'd1 << 63) + (s >> 1), s) << 7;
    endfunction

    localparam longint unsigned PI_Q60       = 4 * atan_q60(0);
    localparam longint unsigned RAD_PER_UNIT = (PI_Q60 / 180) >> ANGLE_FRAC_BITS;

    localparam int RPU_SPLIT = 20;
    localparam int RPU_HI_W  = 20;
    localparam logic [RPU_SPLIT-1:0] RPU_LO = RAD_PER_UNIT[RPU_SPLIT-1:0];
    localparam logic [RPU_HI_W-1:0]  RPU_HI = RAD_PER_UNIT[RPU_SPLIT+RPU_HI_W-1:RPU_SPLIT];

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  neg;
    } t_cordic_lane;

    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [MAG_W-1:0] acc_x;
        logic [REM_W-1:0] rem_y;
        logic [MAG_W-1:0] acc_y;
        logic [DIV_W-1:0] d;
        logic             neg_x;
        logic             neg_y;
        logic             off;
    } t_div_lane;

    typedef struct packed {
        logic [OUT_W-1:0] east_x;
        logic [OUT_W-1:0] north_y;
        logic             off;
        logic             sat;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/gfp_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation by atan(2^-STAGE), registered toward the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module gfp_cordic_cell
    import gfp_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  t_cordic_lane i_lane,
    output t_cordic_lane o_lane
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q60(STAGE));

    logic signed [X_W-1:0] w_x, w_y, w_dx, w_dy;
    logic signed [Z_W-1:0] w_z;
    t_cordic_lane          n_lane, r_lane;

    assign w_x  = i_lane.x;
    assign w_y  = i_lane.y;
    assign w_z  = i_lane.z;
    assign w_dx = w_y >>> STAGE;
    assign w_dy = w_x >>> STAGE;

    always_comb begin
        n_lane.neg = i_lane.neg;
        if (!w_z[Z_W-1]) begin
            n_lane.x = w_x - w_dx;
            n_lane.y = w_y + w_dy;
            n_lane.z = w_z - ATAN;
        end else begin
            n_lane.x = w_x + w_dx;
            n_lane.y = w_y - w_dy;
            n_lane.z = w_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// ----- rtl/gfp_cordic.sv -----
// ---------------------------------------------------------------------------
// Pipelined sine/cosine
// Range reduction, degree-to-radian scaling, a row of rotation cells and
// rounding to Q30, each step registered under the enable.
// ---------------------------------------------------------------------------
`default_nettype none

module gfp_cordic
    import gfp_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    localparam logic signed [X_W-1:0]   INV_GAIN  = X_W'(cordic_inv_gain(STAGES));
    localparam logic signed [X_W-1:0]   RND_HALF  = X_W'(512);
    localparam logic signed [ANG_W:0]   FULL_A    = (ANG_W+1)'(FULL_TURN);
    localparam logic signed [ANG_W:0]   HALF_A    = (ANG_W+1)'(HALF_TURN);
    localparam logic signed [WRAP_W-1:0] HALF_R   = WRAP_W'(HALF_TURN);
    localparam logic signed [WRAP_W-1:0] QUARTER_R = WRAP_W'(QUARTER_TURN);
    localparam int PH_W = RED_W + RPU_HI_W + 1;
    localparam int PL_W = RED_W + RPU_SPLIT + 1;

    logic signed [ANG_W:0]      w_a, w_wrap;
    logic signed [WRAP_W-1:0]   r_wrap, w_fold;
    logic signed [RED_W-1:0]    r_red;
    logic                       w_neg, r_neg2, r_neg3;
    logic signed [PH_W-1:0]     r_ph;
    logic signed [PL_W-1:0]     r_pl;
    logic signed [Z_W+3:0]      w_z;
    t_cordic_lane               r_init;
    t_cordic_lane               w_lane [STAGES+1];
    t_cordic_lane               w_last;
    logic signed [X_W-1:0]      w_fx, w_fy, w_rx, w_ry;
    logic signed [TRIG_W-1:0]   w_c, w_s;
    logic signed [TRIG_W-1:0]   r_sin, r_cos;

    // wrap into [-180, 180)
    assign w_a    = (ANG_W+1)'(i_angle);
    assign w_wrap = (w_a >= HALF_A)  ? w_a - FULL_A :
                    (w_a < -HALF_A)  ? w_a + FULL_A : w_a;

    // fold into [-90, 90], flipping both outputs
    always_comb begin
        w_neg  = 1'b0;
        w_fold = r_wrap;
        if (r_wrap > QUARTER_R) begin
            w_fold = r_wrap - HALF_R;
            w_neg  = 1'b1;
        end else if (r_wrap < -QUARTER_R) begin
            w_fold = r_wrap + HALF_R;
            w_neg  = 1'b1;
        end
    end

    assign w_z = ((Z_W+4)'(r_ph) <<< RPU_SPLIT) + (Z_W+4)'(r_pl);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wrap   <= w_wrap[WRAP_W-1:0];
            r_red    <= w_fold[RED_W-1:0];
            r_neg2   <= w_neg;
            r_ph     <= r_red * $signed({1'b0, RPU_HI});
            r_pl     <= r_red * $signed({1'b0, RPU_LO});
            r_neg3   <= r_neg2;
            r_init.x <= INV_GAIN;
            r_init.y <= '0;
            r_init.z <= w_z[Z_W-1:0];
            r_init.neg <= r_neg3;
        end
    end

    assign w_lane[0] = r_init;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        gfp_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_lane (w_lane[g]),
            .o_lane (w_lane[g+1])
        );
    end

    assign w_last = w_lane[STAGES];
    assign w_fx   = w_last.x;
    assign w_fy   = w_last.y;
    assign w_rx   = (w_fx + RND_HALF) >>> 10;
    assign w_ry   = (w_fy + RND_HALF) >>> 10;
    assign w_c    = w_rx[TRIG_W-1:0];
    assign w_s    = w_ry[TRIG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= w_last.neg ? -w_s : w_s;
            r_cos <= w_last.neg ? -w_c : w_c;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

// ----- rtl/gfp_div_cell.sv -----
// ---------------------------------------------------------------------------
// Restoring divider cell
// Retires one quotient bit for the easting and the northing lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module gfp_div_cell
    import gfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane n_lane, r_lane;

    // shift one dividend bit into the remainder, subtract if it fits
    function automatic logic [REM_W+MAG_W-1:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic [MAG_W-1:0] acc,
        input logic [DIV_W-1:0] d
    );
        logic [REM_W-1:0] sh;
        logic [MAG_W-1:0] a;
        sh = {rem[REM_W-2:0], acc[MAG_W-1]};
        a  = {acc[MAG_W-2:0], 1'b0};
        if (sh >= {1'b0, d}) begin
            sh   = sh - {1'b0, d};
            a[0] = 1'b1;
        end
        return {sh, a};
    endfunction

    always_comb begin
        n_lane = i_lane;
        {n_lane.rem_x, n_lane.acc_x} = div_step(i_lane.rem_x, i_lane.acc_x, i_lane.d);
        {n_lane.rem_y, n_lane.acc_y} = div_step(i_lane.rem_y, i_lane.acc_y, i_lane.d);
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_lane <= n_lane;
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

// ----- rtl/gnomonic_forward_projection.sv -----
// ---------------------------------------------------------------------------
// Spherical gnomonic forward projection
// Latitude/longitude in degrees (Q16) to plane easting/northing in metres.
// ---------------------------------------------------------------------------
//  channel   handshake                    payload
//  point in  i_in_valid / o_in_ready      i_latitude, i_longitude
//  result    o_out_valid / i_out_ready    o_east_x, o_north_y, o_off_hemisphere,
//                                         o_saturated
//  config    i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  One point per cycle while the skid stage is empty; a point passes through the
//  sin/cos cell rows, the product registers and the 57-cell divider row.
//  Synchronous active-low reset clears valid bits and the output/skid flags,
//  zeroes the origin registers and sets the radius to RADIUS_RST.
//  The whole pipeline holds only while the skid stage is full, so a result
//  waiting on the output does not block new transfers.
// ---------------------------------------------------------------------------
`default_nettype none

module gnomonic_forward_projection
    import gfp_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [LAT_W-1:0]      i_latitude,
    input  logic [LON_W-1:0]      i_longitude,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_W-1:0]      o_east_x,
    output logic [OUT_W-1:0]      o_north_y,
    output logic                  o_off_hemisphere,
    output logic                  o_saturated,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CL   = CORDIC_STAGES + 5;
    localparam int LAT  = CL + 5 + MAG_W;
    localparam int QV_W = MAG_W + 1;
    localparam logic signed [QV_W-1:0] OUT_MAX =
        {{(QV_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [QV_W-1:0] OUT_MIN =
        {{(QV_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic signed [PROD_W:0] RND_Q30 = (PROD_W+1)'(64'd1 << 29);

    // config
    logic signed [LAT_W-1:0] r_origin_lat;
    logic signed [LON_W-1:0] r_origin_lon;
    logic [RAD_W-1:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_lat <= '0;
            r_origin_lon <= '0;
            r_radius     <= RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_LAT: r_origin_lat <= i_cfg_data[LAT_W-1:0];
                CFG_ORIGIN_LON: r_origin_lon <= i_cfg_data[LON_W-1:0];
                CFG_RADIUS:     r_radius     <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic             w_en;
    logic [LAT-1:0]   r_vld;
    logic             r_skid_vld, r_out_vld;
    t_result          r_skid, r_out, w_res;

    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    // input stage
    logic signed [LAT_W-1:0] r_lat;
    logic signed [ANG_W-1:0] r_dlon;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat  <= i_latitude;
            r_dlon <= ANG_W'($signed(i_longitude)) - ANG_W'(r_origin_lon);
        end
    end

    logic signed [TRIG_W-1:0] w_sp, w_cp, w_s1, w_c1, w_sd, w_cd;

    gfp_cordic #(.STAGES(CORDIC_STAGES)) u_trig_lat (
        .i_clk (i_clk), .i_en (w_en), .i_angle (ANG_W'(r_lat)),
        .o_sin (w_sp),  .o_cos (w_cp)
    );

    gfp_cordic #(.STAGES(CORDIC_STAGES)) u_trig_org (
        .i_clk (i_clk), .i_en (w_en), .i_angle (ANG_W'(r_origin_lat)),
        .o_sin (w_s1),  .o_cos (w_c1)
    );

    gfp_cordic #(.STAGES(CORDIC_STAGES)) u_trig_dlon (
        .i_clk (i_clk), .i_en (w_en), .i_angle (r_dlon),
        .o_sin (w_sd),  .o_cos (w_cd)
    );

    // products
    logic signed [2*TRIG_W-1:0] w_c1cp, w_s1cp, w_cpsd;
    logic signed [TRIG_W-1:0]   r_t1, r_t2, r_cd1;
    logic signed [PROD_W-1:0]   r_ss1, r_cs1, r_ss2, r_cs2, r_tc, r_tc2;
    logic signed [NUMER_W-1:0]  r_xn1, r_xn2, r_xn3, r_cosc, r_yn;
    logic signed [PROD_W:0]     w_csum, w_ysum;
    logic signed [NUM_W-1:0]    r_numx, r_numy;
    logic [DIV_W-1:0]           r_d;
    logic                       r_off;

    assign w_c1cp = w_c1 * w_cp;
    assign w_s1cp = w_s1 * w_cp;
    assign w_cpsd = w_cp * w_sd;
    assign w_csum = (PROD_W+1)'(r_ss2) + (PROD_W+1)'(r_tc) + RND_Q30;
    assign w_ysum = (PROD_W+1)'(r_cs2) - (PROD_W+1)'(r_tc2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1   <= TRIG_W'(w_c1cp >>> 30);
            r_t2   <= TRIG_W'(w_s1cp >>> 30);
            r_ss1  <= w_s1 * w_sp;
            r_cs1  <= w_c1 * w_sp;
            r_xn1  <= NUMER_W'(w_cpsd >>> 30);
            r_cd1  <= w_cd;

            r_tc   <= r_t1 * r_cd1;
            r_tc2  <= r_t2 * r_cd1;
            r_ss2  <= r_ss1;
            r_cs2  <= r_cs1;
            r_xn2  <= r_xn1;

            r_cosc <= NUMER_W'(w_csum >>> 30);
            r_yn   <= NUMER_W'(w_ysum >>> 30);
            r_xn3  <= r_xn2;

            r_numx <= $signed({1'b0, r_radius}) * r_xn3;
            r_numy <= $signed({1'b0, r_radius}) * r_yn;
            r_off  <= r_cosc[NUMER_W-1] || (r_cosc == '0);
            r_d    <= r_cosc[DIV_W-1:0];
        end
    end

    // divider row
    logic signed [NUM_W-1:0] w_ax, w_ay;
    t_div_lane               w_div [MAG_W+1];

    assign w_ax = r_numx[NUM_W-1] ? -r_numx : r_numx;
    assign w_ay = r_numy[NUM_W-1] ? -r_numy : r_numy;

    always_comb begin
        w_div[0].rem_x = '0;
        w_div[0].acc_x = w_ax[MAG_W-1:0];
        w_div[0].rem_y = '0;
        w_div[0].acc_y = w_ay[MAG_W-1:0];
        w_div[0].d     = r_d;
        w_div[0].neg_x = r_numx[NUM_W-1];
        w_div[0].neg_y = r_numy[NUM_W-1];
        w_div[0].off   = r_off;
    end

    for (genvar g = 0; g < MAG_W; g++) begin : g_div
        gfp_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_div[g]),
            .o_lane (w_div[g+1])
        );
    end

    // sign, clip, off-hemisphere override
    t_div_lane               w_tail;
    logic signed [QV_W-1:0]  w_qx, w_qy, w_vx, w_vy, w_cx, w_cy;
    logic                    w_satx, w_saty;

    assign w_tail = w_div[MAG_W];
    assign w_qx   = $signed({1'b0, w_tail.acc_x});
    assign w_qy   = $signed({1'b0, w_tail.acc_y});
    assign w_vx   = w_tail.neg_x ? -w_qx : w_qx;
    assign w_vy   = w_tail.neg_y ? -w_qy : w_qy;
    assign w_satx = (w_vx > OUT_MAX) || (w_vx < OUT_MIN);
    assign w_saty = (w_vy > OUT_MAX) || (w_vy < OUT_MIN);
    assign w_cx   = (w_vx > OUT_MAX) ? OUT_MAX : (w_vx < OUT_MIN) ? OUT_MIN : w_vx;
    assign w_cy   = (w_vy > OUT_MAX) ? OUT_MAX : (w_vy < OUT_MIN) ? OUT_MIN : w_vy;

    always_comb begin
        w_res.off = w_tail.off;
        if (w_tail.off) begin
            w_res.east_x  = '0;
            w_res.north_y = '0;
            w_res.sat     = 1'b0;
        end else begin
            w_res.east_x  = w_cx[OUT_W-1:0];
            w_res.north_y = w_cy[OUT_W-1:0];
            w_res.sat     = w_satx || w_saty;
        end
    end

    // valid tracking and output/skid registers
    logic w_fire_out, w_new;

    assign w_fire_out = r_out_vld && i_out_ready;
    assign w_new      = w_en && r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en)
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
            if (r_skid_vld) begin
                if (w_fire_out) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end
            end else if (w_new) begin
                if (!r_out_vld || w_fire_out) begin
                    r_out     <= w_res;
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid     <= w_res;
                    r_skid_vld <= 1'b1;
                end
            end else if (w_fire_out) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_east_x         = r_out.east_x;
    assign o_north_y        = r_out.north_y;
    assign o_off_hemisphere = r_out.off;
    assign o_saturated      = r_out.sat;

endmodule

`default_nettype wire

// ----- rtl/gfp_checker.sv -----
// ---------------------------------------------------------------------------
// Gnomonic projection port checker
// Port-level properties of the projection block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gnomonic_forward_projection_defines.svh"

module gfp_checker
    import gfp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [OUT_W-1:0]      o_east_x,
    input logic [OUT_W-1:0]      o_north_y,
    input logic                  o_off_hemisphere,
    input logic                  o_saturated
);

    // off-hemisphere points carry zero coordinates and no clip flag
    `GFP_ASSERT_IMP(a_off_zero, o_out_valid && o_off_hemisphere, (o_east_x == '0) && (o_north_y == '0) && !o_saturated, "off-hemisphere result not zeroed")

    // a clipped result sits on a range bound
    `GFP_ASSERT_IMP(a_sat_bound, o_out_valid && o_saturated, (o_east_x == 48'h7FFF_FFFF_FFFF) || (o_east_x == 48'h8000_0000_0000) || (o_north_y == 48'h7FFF_FFFF_FFFF) || (o_north_y == 48'h8000_0000_0000), "saturated flag without bound value")

    // input only backs up behind a waiting result
    `GFP_ASSERT_IMP(a_stall_cause, !o_in_ready, o_out_valid, "input stalled with no pending result")

    // a stalled result holds
    `GFP_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_east_x) && $stable(o_north_y), "result changed while stalled")

    // reset leaves the block empty and ready
    `GFP_ASSERT_RST(a_rst_empty, !i_rst_n, o_in_ready && !o_out_valid, "not empty after reset")

endmodule

bind gnomonic_forward_projection gfp_checker u_gfp_checker (.*);

`default_nettype wire

// ----- verif/gnomonic_forward_projection_tb.sv -----
// ---------------------------------------------------------------------------
// Gnomonic forward projection testbench
// Streams lat/lon points through the projector under several origin and
// radius settings, with random gaps and output stalls, and checks every
// result against a bit-exact fixed-point CORDIC predictor.
// ---------------------------------------------------------------------------
`default_nettype none

class gfp_scoreboard;
    localparam int STAGES = 32;

    longint atan_q60[STAGES];
    longint rad_per_unit;
    longint cordic_start;

    logic signed [gfp_pkg::LAT_W-1:0] org_lat;
    logic signed [gfp_pkg::LON_W-1:0] org_lon;
    logic [gfp_pkg::RAD_W-1:0]        radius;

    gfp_pkg::t_result expected_q[$];
    int errors;

    function new();
        longint unsigned a0;
        longint unsigned p;
        longint unsigned s;
        a0 = series_atan(2) + series_atan(3);
        p  = 64'd1 << 60;
        for (int i = 0; i < STAGES; i++) begin
            if (i == 0)
                atan_q60[i] = a0;
            else if (i < 20)
                atan_q60[i] = series_atan(64'd1 << i);
            else
                atan_q60[i] = 64'd1 << (60 - i);
            if (2 * i < 64)
                p += p >> (2 * i);
        end
        rad_per_unit = ((4 * a0) / 180) >> gfp_pkg::ANGLE_FRAC_BITS;
        s            = int_sqrt(p);
        cordic_start = (((64'd1 << 63) + s / 2) / s) << 7;
        org_lat = '0;
        org_lon = '0;
        radius  = gfp_pkg::RADIUS_RST;
        errors  = 0;
    endfunction

    // atan(1/n) in Q60 by truncated alternating series
    function longint unsigned series_atan(longint unsigned n);
        longint unsigned term;
        longint unsigned sum;
        longint unsigned k;
        term = (64'd1 << 60) / n;
        sum  = term;
        k    = 1;
        term = term / (n * n);
        while (term != 0) begin
            if (k[0])
                sum -= term / (2 * k + 1);
            else
                sum += term / (2 * k + 1);
            k++;
            term = term / (n * n);
        end
        return sum;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b    = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v    -= root + b;
                root  = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // Q30 sine/cosine of an angle in degrees * 2^16
    function void sin_cos(longint a, output longint sn, output longint cs);
        longint full;
        longint half;
        longint quarter;
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        full    = longint'(360) << gfp_pkg::ANGLE_FRAC_BITS;
        half    = longint'(180) << gfp_pkg::ANGLE_FRAC_BITS;
        quarter = longint'(90) << gfp_pkg::ANGLE_FRAC_BITS;
        r    = a % full;
        flip = 0;
        if (r >= half)
            r -= full;
        if (r < -half)
            r += full;
        if (r > quarter) begin
            r -= half;
            flip = 1;
        end else if (r < -quarter) begin
            r += half;
            flip = 1;
        end
        x = cordic_start;
        y = 0;
        z = r * rad_per_unit;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_q60[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_q60[i];
            end
        end
        x  = (x + 512) >>> 10;
        y  = (y + 512) >>> 10;
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function longint clip(longint v, inout bit sat);
        longint hi;
        hi = (longint'(1) <<< 47) - 1;
        if (v > hi) begin
            sat = 1;
            return hi;
        end
        if (v < -hi - 1) begin
            sat = 1;
            return -hi - 1;
        end
        return v;
    endfunction

    function void write_reg(logic [gfp_pkg::CFG_IDX_W-1:0] idx,
                            logic [gfp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            gfp_pkg::CFG_ORIGIN_LAT: org_lat = data[gfp_pkg::LAT_W-1:0];
            gfp_pkg::CFG_ORIGIN_LON: org_lon = data[gfp_pkg::LON_W-1:0];
            gfp_pkg::CFG_RADIUS:     radius  = data[gfp_pkg::RAD_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_point(logic [gfp_pkg::LAT_W-1:0] lat,
                             logic [gfp_pkg::LON_W-1:0] lon);
        longint sp, cp, s1, c1, sd, cd, t, cosc, xn, yn, r, x, y;
        bit     sat;
        gfp_pkg::t_result res;
        sin_cos(longint'($signed(lat)), sp, cp);
        sin_cos(longint'(org_lat), s1, c1);
        sin_cos(longint'($signed(lon)) - longint'(org_lon), sd, cd);
        t    = (c1 * cp) >>> 30;
        cosc = (s1 * sp + t * cd + (longint'(1) <<< 29)) >>> 30;
        xn   = (cp * sd) >>> 30;
        t    = (s1 * cp) >>> 30;
        yn   = (c1 * sp - t * cd) >>> 30;
        r    = longint'(radius);
        x    = 0;
        y    = 0;
        sat  = 0;
        if (cosc > 0) begin
            x = clip((r * xn) / cosc, sat);
            y = clip((r * yn) / cosc, sat);
        end
        res.east_x  = x[gfp_pkg::OUT_W-1:0];
        res.north_y = y[gfp_pkg::OUT_W-1:0];
        res.off     = (cosc <= 0);
        res.sat     = sat;
        expected_q.push_back(res);
    endfunction

    function void check(logic [gfp_pkg::OUT_W-1:0] ex, logic [gfp_pkg::OUT_W-1:0] ny,
                        logic off, logic sat);
        gfp_pkg::t_result e;
        if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected: x=%0d y=%0d", $time,
                     $signed(ex), $signed(ny));
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (ex !== e.east_x) begin
            $display("%0t: east_x expected %0d got %0d", $time, $signed(e.east_x), $signed(ex));
            errors++;
        end
        if (ny !== e.north_y) begin
            $display("%0t: north_y expected %0d got %0d", $time,
                     $signed(e.north_y), $signed(ny));
            errors++;
        end
        if (off !== e.off) begin
            $display("%0t: off_hemisphere expected %0b got %0b", $time, e.off, off);
            errors++;
        end
        if (sat !== e.sat) begin
            $display("%0t: saturated expected %0b got %0b", $time, e.sat, sat);
            errors++;
        end
    endfunction
endclass

module gnomonic_forward_projection_tb;
    import gfp_pkg::*;

    localparam longint DEG       = 65536;
    localparam int     LAT_MAX   = 90 * 65536;
    localparam int     LON_MAX   = 180 * 65536;
    localparam int     PIPE_WAIT = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [LAT_W-1:0]      i_latitude;
    logic [LON_W-1:0]      i_longitude;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [OUT_W-1:0]      o_east_x;
    logic [OUT_W-1:0]      o_north_y;
    logic                  o_off_hemisphere;
    logic                  o_saturated;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gfp_scoreboard projection_sb;
    bit no_gaps;
    int results_seen;

    gnomonic_forward_projection DUT (.*);

    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    initial begin
        i_rst_n     = 0;
        i_in_valid  = 0;
        i_latitude  = '0;
        i_longitude = '0;
        i_out_ready = 0;
        i_cfg_we    = 0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
    end

    // transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            projection_sb.note_point(i_latitude, i_longitude);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            projection_sb.check(o_east_x, o_north_y, o_off_hemisphere, o_saturated);
            results_seen++;
        end
    end

    task automatic send_point(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1;
        i_latitude  <= lat;
        i_longitude <= lon;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        // last transfer is done; stop offering it again
        i_in_valid <= 0;
        while (projection_sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic load_config(input longint lat0, input longint lon0, input longint rad);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        i_cfg_we <= 1; i_cfg_idx <= CFG_ORIGIN_LAT; i_cfg_data <= CFG_DATA_W'(lat0);
        projection_sb.write_reg(CFG_ORIGIN_LAT, CFG_DATA_W'(lat0));
        @(posedge i_clk);
        i_cfg_idx <= CFG_ORIGIN_LON; i_cfg_data <= CFG_DATA_W'(lon0);
        projection_sb.write_reg(CFG_ORIGIN_LON, CFG_DATA_W'(lon0));
        @(posedge i_clk);
        i_cfg_idx <= CFG_RADIUS; i_cfg_data <= CFG_DATA_W'(rad);
        projection_sb.write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
        @(posedge i_clk);
        // unused index: must be ignored
        i_cfg_idx <= CFG_IDX_SPARE; i_cfg_data <= junk;
        projection_sb.write_reg(CFG_IDX_SPARE, junk);
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic longint clamp(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    task automatic random_point();
        longint lat, lon;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            // near the projection center, where results are meaningful
            lat = clamp(longint'($signed(projection_sb.org_lat)) +
                        $signed($urandom_range(0, 140 * DEG)) - 70 * DEG, LAT_MAX);
            lon = clamp(longint'($signed(projection_sb.org_lon)) +
                        $signed($urandom_range(0, 160 * DEG)) - 80 * DEG, LON_MAX);
        end else if (kind <= 7) begin
            lat = $signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
            lon = $signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
        end else if (kind == 8) begin
            lat = $urandom();
            lon = $urandom();
        end else begin
            // right at the horizon, where cos c is tiny
            lat = 0;
            lon = longint'($signed(projection_sb.org_lon)) + 90 * DEG -
                  $urandom_range(0, 3);
        end
        send_point(LAT_W'(lat), LON_W'(lon));
    endtask

    // receiver: random stalls, one long hold-off to back the pipeline up
    initial begin
        int stall;
        bit long_done;
        long_done = 0;
        @(posedge i_rst_n);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 17);
            if (!long_done && results_seen >= 80) begin
                stall     = 2000;
                long_done = 1;
            end
            if (stall > 0) begin
                i_out_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #2000000;
        $display("gnomonic_forward_projection_tb NOT OK");
        $finish;
    end

    initial begin
        projection_sb = new();
        results_seen  = 0;
        no_gaps       = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset config: center, poles, date line, horizon, antipode, raw extremes
        send_point(LAT_W'(0), LON_W'(0));
        send_point(LAT_W'(LAT_MAX), LON_W'(0));
        send_point(LAT_W'(-LAT_MAX), LON_W'(0));
        send_point(LAT_W'(0), LON_W'(LON_MAX));
        send_point(LAT_W'(0), LON_W'(-LON_MAX));
        send_point(LAT_W'(0), LON_W'(90 * DEG));
        send_point(LAT_W'(0), LON_W'(90 * DEG - 1));
        send_point(LAT_W'(0), LON_W'(-90 * DEG + 1));
        send_point(LAT_W'(45 * DEG), LON_W'(45 * DEG));
        send_point(LAT_W'(-30 * DEG), LON_W'(-60 * DEG));
        send_point(24'h7FFFFF, 25'h0FFFFFF);
        send_point(24'h800000, 25'h1000000);
        send_point(24'hFFFFFF, 25'h1FFFFFF);
        send_point(LAT_W'(1), LON_W'(1));
        for (int i = 0; i < 60; i++)
            random_point();
        drain_results();

        for (int ph = 0; ph < 7; ph++) begin
            no_gaps = (ph == 2 || ph == 5);
            case (ph)
                0: load_config(45 * DEG, -90 * DEG, 24'hFFFFFF);
                1: load_config(-LAT_MAX, LON_MAX, 1);
                2: load_config(LAT_MAX, -LON_MAX, 0);
                3: load_config(-12 * DEG - 7, 33 * DEG + 3, 6371000);
                4: load_config(24'h800000, 25'h1000000, 24'h800000);
                5: load_config(24'h7FFFFF, 25'h0FFFFFF, 6378137);
                default: load_config($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX,
                                     $signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX,
                                     $urandom_range(1, 24'hFFFFFF));
            endcase
            // the long output stall lands in the busy middle of the run
            for (int i = 0; i < ((ph == 0) ? 150 : 45); i++)
                random_point();
            drain_results();
        end

        drain_results();
        if (projection_sb.errors == 0 && projection_sb.expected_q.size() == 0)
            $display("gnomonic_forward_projection_tb OK");
        else
            $display("gnomonic_forward_projection_tb NOT OK");
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/gfp_pkg.sv
rtl/gfp_cordic_cell.sv
rtl/gfp_cordic.sv
rtl/gfp_div_cell.sv
rtl/gnomonic_forward_projection.sv
rtl/gfp_checker.sv
verif/gnomonic_forward_projection_tb.sv
